// ----- design/trimmed_mean_window_filter_top_assert.svh -----
// assertion macros for the trimmed mean window filter checker
// plain sva wrappers, no other dependencies
`ifndef TRIMMED_MEAN_WINDOW_FILTER_TOP_ASSERT_SVH
`define TRIMMED_MEAN_WINDOW_FILTER_TOP_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define TMWF_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while in reset
`define TMWF_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/tmwf_pkg.sv -----
// shared constants and types of the trimmed mean window filter
// no dependencies
`default_nettype none

package tmwf_pkg;

  // beat layouts
  localparam int RAW_W       = 10;
  localparam int IN_TDATA_W  = 16;
  localparam int IN_TUSER_W  = 2;
  localparam int TEMP_W      = 12;
  localparam int OUT_TDATA_W = 16;

  // tuser bit positions
  localparam int TUSER_SEED  = 0;
  localparam int TUSER_VALID = 1;

  // configuration port
  localparam int APB_DW          = 32;
  localparam int APB_AW          = 3;
  localparam int OFS_W           = 10;
  localparam int REG_TEMP_OFFSET = 0;

  // temperature arithmetic
  localparam int KCELSIUS = 273;
  localparam int TEMP_MIN = -2048;
  localparam int TEMP_MAX = 2047;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_RDI  = 6'b000010,
    ST_CAPI = 6'b000100,
    ST_SCAN = 6'b001000,
    ST_DIV  = 6'b010000,
    ST_FIN  = 6'b100000
  } state_e;

endpackage

`default_nettype wire

// ----- design/tmwf_ram.sv -----
// generic single-port-write, single-port-read ram with registered read
// no dependencies
`default_nettype none

module tmwf_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- design/trimmed_mean_window_filter_top.sv -----
// top level of the trimmed mean window filter
// uses tmwf_pkg and tmwf_ram
//
// Usage:
//   s_axis carries one ADC sample per beat: tdata holds raw_sample, tuser holds
//   seed_all and sample_valid. Each accepted beat yields exactly one m_axis beat
//   carrying the temperature: trimmed window mean + temp_offset - 273.
//   A seed beat sets every window entry to its sample; otherwise a valid,
//   nonzero sample overwrites the oldest entry of the ring.
// Operation:
//   one item at a time: the input closes on the accepting edge and opens
//   again once the result is loaded into the output register. Most of the
//   work is the rank scan: each entry is compared with every entry through
//   the single read port of the window ram, one comparison a cycle, then
//   one reciprocal multiply divides by the kept count.
// Reset:
//   window reads as all zeros, ring position zero, temp_offset zero. No
//   clearing pass; per-entry valid bits cover the reset and seed values.
// Stall:
//   the result sits in an output register; the next sample is accepted while
//   it waits. A finished second result holds until the first is taken.
// Configuration:
//   APB, temp_offset at byte address 0, write only while idle.
`default_nettype none

module trimmed_mean_window_filter_top #(
  parameter int WINDOW      = 32,
  parameter int TRIM        = 6,
  parameter int SAMPLE_BITS = 10
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  // input stream
  input  wire logic                                s_axis_tvalid,
  output logic                                     s_axis_tready,
  // raw_sample[9:0], zeros above
  input  wire logic [tmwf_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  // seed_all[0], sample_valid[1]
  input  wire logic [tmwf_pkg::IN_TUSER_W-1:0]     s_axis_tuser,
  // output stream
  output logic                                     m_axis_tvalid,
  input  wire logic                                m_axis_tready,
  // temperature[11:0], zeros above
  output logic      [tmwf_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  // configuration port
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [tmwf_pkg::APB_AW-1:0]         paddr,
  input  wire logic [tmwf_pkg::APB_DW-1:0]         pwdata,
  output logic      [tmwf_pkg::APB_DW-1:0]         prdata,
  output logic                                     pready
);

  localparam int IW       = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int TRIM_EFF = (2 * TRIM >= WINDOW) ? (WINDOW - 1) / 2 : TRIM;
  localparam int KEEP     = WINDOW - 2 * TRIM_EFF;
  localparam int SUMW     = SAMPLE_BITS + IW;
  localparam int DSH      = SUMW + $clog2(KEEP);
  localparam int RECIP    = ((1 << DSH) + KEEP - 1) / KEEP;
  localparam int MW       = $clog2(RECIP + 1);
  localparam int PW       = SUMW + MW;
  localparam int TW       = SAMPLE_BITS + 4;
  localparam int SB       = SAMPLE_BITS;

  tmwf_pkg::state_e state_q, state_d;

  logic [IW-1:0]     i_q, i_d;
  logic [IW-1:0]     jd_q, jd_d;
  logic [IW-1:0]     rank_q, rank_d;
  logic [SB-1:0]     vi_q, vi_d;
  logic [SUMW-1:0]   sum_q, sum_d;
  logic [IW-1:0]     wr_idx_q;
  logic [WINDOW-1:0] valid_q;
  logic [SB-1:0]     dflt_q;
  logic              vld_rd_q;
  logic signed [tmwf_pkg::OFS_W-1:0] ofs_q;
  logic              out_valid_q;
  logic [tmwf_pkg::TEMP_W-1:0] out_data_q;

  // input beat decode
  logic [tmwf_pkg::IN_TDATA_W-1:0] raw_ext;
  logic [SB-1:0] sample;
  logic          seed;
  logic          svalid;
  logic          in_fire;
  logic          store;

  assign raw_ext = {{(tmwf_pkg::IN_TDATA_W - tmwf_pkg::RAW_W){1'b0}},
                    s_axis_tdata[tmwf_pkg::RAW_W-1:0]};
  assign sample  = raw_ext[SB-1:0];
  assign seed    = s_axis_tuser[tmwf_pkg::TUSER_SEED];
  assign svalid  = s_axis_tuser[tmwf_pkg::TUSER_VALID];
  assign s_axis_tready = (state_q == tmwf_pkg::ST_IDLE);
  assign in_fire = s_axis_tvalid && s_axis_tready;
  assign store   = in_fire && !seed && svalid && (sample != '0);

  // window ram
  logic [IW-1:0] raddr;
  logic [SB-1:0] ram_rdata;
  logic [SB-1:0] rd_val;

  tmwf_ram #(
    .WIDTH (SB),
    .DEPTH (WINDOW)
  ) u_window (
    .clk_i   (clk_i),
    .we_i    (store),
    .waddr_i (wr_idx_q),
    .wdata_i (sample),
    .raddr_i (raddr),
    .rdata_o (ram_rdata)
  );

  // an entry not written since reset or the last seed reads as the default
  assign rd_val = vld_rd_q ? ram_rdata : dflt_q;

  // read address per state
  always_comb begin
    unique case (state_q)
      tmwf_pkg::ST_RDI:  raddr = i_q;
      tmwf_pkg::ST_SCAN: raddr = (jd_q == IW'(WINDOW - 1)) ? '0 : jd_q + 1'b1;
      default:           raddr = '0;
    endcase
  end

  // rank of entry i: entries smaller, or equal and earlier
  logic          lt;
  logic [IW-1:0] rank_nx;
  logic          keep;

  assign lt      = (rd_val < vi_q) || ((rd_val == vi_q) && (jd_q < i_q));
  assign rank_nx = rank_q + IW'(lt);
  assign keep    = (rank_nx >= IW'(TRIM_EFF)) &&
                   ({1'b0, rank_nx} < (IW + 1)'(WINDOW - TRIM_EFF));

  // divide by the kept count through a reciprocal multiply
  logic [PW-1:0] prod;

  assign prod = PW'(sum_q) * PW'(RECIP);

  // temperature from the quotient, saturated to the output range
  logic signed [TW-1:0] t_full;
  logic [tmwf_pkg::TEMP_W-1:0] temp;

  assign t_full = $signed({4'b0000, sum_q[SB-1:0]}) + TW'(ofs_q)
                  - TW'(tmwf_pkg::KCELSIUS);

  always_comb begin
    if (t_full < TW'(tmwf_pkg::TEMP_MIN)) begin
      temp = tmwf_pkg::TEMP_W'(tmwf_pkg::TEMP_MIN);
    end else if (t_full > TW'(tmwf_pkg::TEMP_MAX)) begin
      temp = tmwf_pkg::TEMP_W'(tmwf_pkg::TEMP_MAX);
    end else begin
      temp = t_full[tmwf_pkg::TEMP_W-1:0];
    end
  end

  logic out_load;
  assign out_load = (state_q == tmwf_pkg::ST_FIN) && (!out_valid_q || m_axis_tready);

  // sequencer
  always_comb begin
    state_d = state_q;
    i_d     = i_q;
    jd_d    = jd_q;
    rank_d  = rank_q;
    vi_d    = vi_q;
    sum_d   = sum_q;
    unique case (state_q)
      tmwf_pkg::ST_IDLE: begin
        if (in_fire) begin
          i_d     = '0;
          sum_d   = '0;
          state_d = tmwf_pkg::ST_RDI;
        end
      end
      tmwf_pkg::ST_RDI: begin
        state_d = tmwf_pkg::ST_CAPI;
      end
      tmwf_pkg::ST_CAPI: begin
        vi_d    = rd_val;
        jd_d    = '0;
        rank_d  = '0;
        state_d = tmwf_pkg::ST_SCAN;
      end
      tmwf_pkg::ST_SCAN: begin
        rank_d = rank_nx;
        jd_d   = jd_q + 1'b1;
        if (jd_q == IW'(WINDOW - 1)) begin
          if (keep) begin
            sum_d = sum_q + SUMW'(vi_q);
          end
          if (i_q == IW'(WINDOW - 1)) begin
            state_d = tmwf_pkg::ST_DIV;
          end else begin
            i_d     = i_q + 1'b1;
            state_d = tmwf_pkg::ST_RDI;
          end
        end
      end
      tmwf_pkg::ST_DIV: begin
        sum_d   = SUMW'(prod >> DSH);
        state_d = tmwf_pkg::ST_FIN;
      end
      tmwf_pkg::ST_FIN: begin
        if (out_load) begin
          state_d = tmwf_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = tmwf_pkg::ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tmwf_pkg::ST_IDLE;
      i_q     <= '0;
      jd_q    <= '0;
      rank_q  <= '0;
    end else begin
      state_q <= state_d;
      i_q     <= i_d;
      jd_q    <= jd_d;
      rank_q  <= rank_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    vi_q     <= vi_d;
    sum_q    <= sum_d;
    vld_rd_q <= valid_q[raddr];
  end

  // ring position, valid bits and default value
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_idx_q <= '0;
      valid_q  <= '0;
      dflt_q   <= '0;
    end else if (in_fire && seed) begin
      valid_q <= '0;
      dflt_q  <= sample;
    end else if (store) begin
      valid_q[wr_idx_q] <= 1'b1;
      wr_idx_q <= (wr_idx_q == IW'(WINDOW - 1)) ? '0 : wr_idx_q + 1'b1;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q <= temp;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(tmwf_pkg::OUT_TDATA_W - tmwf_pkg::TEMP_W){1'b0}}, out_data_q};

  // configuration register
  logic cfg_sel;
  assign cfg_sel = (paddr[tmwf_pkg::APB_AW-1:2] == 1'(tmwf_pkg::REG_TEMP_OFFSET));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ofs_q <= '0;
    end else if (psel && penable && pwrite && pready && cfg_sel) begin
      ofs_q <= pwdata[tmwf_pkg::OFS_W-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = cfg_sel ?
                  {{(tmwf_pkg::APB_DW - tmwf_pkg::OFS_W){ofs_q[tmwf_pkg::OFS_W-1]}}, ofs_q} :
                  '0;

endmodule

`default_nettype wire

// ----- design/tmwf_checker.sv -----
// port-level checks of the trimmed mean window filter, bound to the top level
// uses trimmed_mean_window_filter_top_assert.svh and tmwf_pkg
`default_nettype none

`include "trimmed_mean_window_filter_top_assert.svh"

module tmwf_checker (
  input wire logic                             clk_i,
  input wire logic                             rst_ni,
  input wire logic                             s_axis_tvalid,
  input wire logic                             s_axis_tready,
  input wire logic                             m_axis_tvalid,
  input wire logic                             m_axis_tready,
  input wire logic [tmwf_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input wire logic                             pready
);

  // one item at a time: an accepted beat closes the input until its result
  `TMWF_ASSERT_NXT(a_busy_after_accept, clk_i, rst_ni, s_axis_tvalid && s_axis_tready, !s_axis_tready, "input accepted again right after a beat")

  // the padding above the temperature stays zero
  `TMWF_ASSERT_IMP(a_out_pad_zero, clk_i, rst_ni, m_axis_tvalid, m_axis_tdata[tmwf_pkg::OUT_TDATA_W-1:tmwf_pkg::TEMP_W] == '0, "nonzero padding in output beat")

  // a stalled result holds its value
  `TMWF_ASSERT_NXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "stalled output beat changed")

  // configuration port never waits
  `TMWF_ASSERT_IMP(a_pready_high, clk_i, rst_ni, 1'b1, pready, "pready dropped")

endmodule

bind trimmed_mean_window_filter_top tmwf_checker u_tmwf_checker (.*);

`default_nettype wire

// ----- tb/tb_trimmed_mean_window_filter_top.sv -----
// self-checking testbench of the trimmed mean window filter
// depends on tmwf_pkg and trimmed_mean_window_filter_top; keeps its own window model
`timescale 1ns / 1ps

module tb_trimmed_mean_window_filter_top;

  localparam int WINDOW      = 32;
  localparam int TRIM        = 6;
  localparam int SAMPLE_BITS = 10;
  localparam int TRIM_EFF    = (2 * TRIM >= WINDOW) ? (WINDOW - 1) / 2 : TRIM;
  localparam int LATENCY     = WINDOW * (WINDOW + 2) + 2;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int PHASE_ITEMS = 100;
  localparam int NUM_PHASES  = 5;
  localparam int IN_TDATA_W  = tmwf_pkg::IN_TDATA_W;
  localparam int IN_TUSER_W  = tmwf_pkg::IN_TUSER_W;
  localparam int OUT_TDATA_W = tmwf_pkg::OUT_TDATA_W;
  localparam int APB_AW      = tmwf_pkg::APB_AW;
  localparam int APB_DW      = tmwf_pkg::APB_DW;
  localparam int OFS_W       = tmwf_pkg::OFS_W;
  localparam int TEMP_W      = tmwf_pkg::TEMP_W;
  localparam int RAW_W       = tmwf_pkg::RAW_W;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                    s_axis_tvalid = 1'b0;
  logic                    s_axis_tready;
  // raw_sample[9:0], zeros above
  logic [IN_TDATA_W-1:0]   s_axis_tdata  = '0;
  // seed_all[0], sample_valid[1]
  logic [IN_TUSER_W-1:0]   s_axis_tuser  = '0;
  logic                    m_axis_tvalid;
  logic                    m_axis_tready = 1'b0;
  // temperature[11:0], zeros above
  logic [OUT_TDATA_W-1:0]  m_axis_tdata;
  logic                    psel    = 1'b0;
  logic                    penable = 1'b0;
  logic                    pwrite  = 1'b0;
  logic [APB_AW-1:0]       paddr   = '0;
  logic [APB_DW-1:0]       pwdata  = '0;
  logic [APB_DW-1:0]       prdata;
  logic                    pready;

  // window model and calibration
  logic [SAMPLE_BITS-1:0]  window_model [WINDOW];
  int                      ring_pos;
  logic signed [OFS_W-1:0] offset_model;
  logic [TEMP_W-1:0]       temp_expect_q [$];

  // stimulus controls and tallies
  bit src_idle_en;
  bit sink_idle_en;
  int stall_left;
  int idle_cycles;
  int fail_count;
  int samples_sent;
  int seeds_sent;
  int stores_sent;
  int temps_checked;
  int offsets_set;
  int level;

  trimmed_mean_window_filter_top #(
    .WINDOW      (WINDOW),
    .TRIM        (TRIM),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 30);
    return $urandom_range(100, 1300);
  endfunction

  // trimmed mean of the modeled window plus offset minus 273, saturated
  function automatic logic [TEMP_W-1:0] predict_temperature();
    int vals [WINDOW];
    int i;
    int j;
    int key;
    int total;
    int t;
    for (i = 0; i < WINDOW; i++) vals[i] = window_model[i];
    for (i = 1; i < WINDOW; i++) begin
      key = vals[i];
      j = i - 1;
      while (j >= 0 && vals[j] > key) begin
        vals[j + 1] = vals[j];
        j--;
      end
      vals[j + 1] = key;
    end
    total = 0;
    for (i = TRIM_EFF; i < WINDOW - TRIM_EFF; i++) total += vals[i];
    t = total / (WINDOW - 2 * TRIM_EFF) + int'(offset_model) - tmwf_pkg::KCELSIUS;
    if (t < tmwf_pkg::TEMP_MIN) t = tmwf_pkg::TEMP_MIN;
    if (t > tmwf_pkg::TEMP_MAX) t = tmwf_pkg::TEMP_MAX;
    return t[TEMP_W-1:0];
  endfunction

  // seed fills the window, a valid nonzero sample replaces the oldest entry
  task automatic update_window(input bit seed, input bit valid, input logic [RAW_W-1:0] raw);
    logic [SAMPLE_BITS-1:0] s;
    s = raw[SAMPLE_BITS-1:0];
    if (seed) begin
      for (int i = 0; i < WINDOW; i++) window_model[i] = s;
      seeds_sent++;
    end else if (valid && s != 0) begin
      window_model[ring_pos] = s;
      ring_pos = (ring_pos + 1) % WINDOW;
      stores_sent++;
    end
  endtask

  // one sample beat; valid stays high unless a gap follows
  task automatic send_sample(input bit seed, input bit valid, input logic [RAW_W-1:0] raw);
    logic [IN_TUSER_W-1:0] user;
    int gap;
    user = '0;
    user[tmwf_pkg::TUSER_SEED]  = seed;
    user[tmwf_pkg::TUSER_VALID] = valid;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_TDATA_W'(raw);
    s_axis_tuser  <= user;
    do @(posedge clk_i); while (!s_axis_tready);
    update_window(seed, valid, raw);
    temp_expect_q.push_back(predict_temperature());
    samples_sent++;
    gap = (src_idle_en && $urandom_range(0, 99) < 40) ? pick_gap() : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= IN_TDATA_W'($urandom);
      s_axis_tuser  <= IN_TUSER_W'($urandom);
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // drop valid after the last beat of a burst
  task automatic end_burst();
    s_axis_tvalid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (temp_expect_q.size() != 0) @(posedge clk_i);
  endtask

  // one apb transfer: setup cycle, access cycle, then back to idle
  task automatic apb_transfer(input bit is_write, input logic [APB_AW-1:0] addr,
                              input logic [APB_DW-1:0] wdata, output logic [APB_DW-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= is_write;
    paddr   <= addr;
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // write temp_offset and read it back
  task automatic set_temp_offset(input logic signed [OFS_W-1:0] value);
    logic [APB_DW-1:0] rd;
    logic [APB_AW-1:0] addr;
    addr = APB_AW'(4 * tmwf_pkg::REG_TEMP_OFFSET);
    apb_transfer(1'b1, addr, APB_DW'(signed'(value)), rd);
    offset_model = value;
    offsets_set++;
    apb_transfer(1'b0, addr, '0, rd);
    if (rd[OFS_W-1:0] !== value) begin
      $error("temp_offset: expected %0d, got %0d", value, $signed(rd[OFS_W-1:0]));
      fail_count++;
    end
  endtask

  // compare one temperature beat with the oldest expectation
  task automatic check_temperature(input logic [OUT_TDATA_W-1:0] data);
    logic [TEMP_W-1:0] exp_t;
    if (temp_expect_q.size() == 0) begin
      $error("temperature: no beat expected, got %0d", $signed(data[TEMP_W-1:0]));
      fail_count++;
    end else begin
      exp_t = temp_expect_q.pop_front();
      temps_checked++;
      if (data[TEMP_W-1:0] !== exp_t) begin
        $error("temperature: expected %0d, got %0d", $signed(exp_t), $signed(data[TEMP_W-1:0]));
        fail_count++;
      end
      if (data[OUT_TDATA_W-1:TEMP_W] !== '0) begin
        $error("tdata padding: expected 0, got %0h", data[OUT_TDATA_W-1:TEMP_W]);
        fail_count++;
      end
    end
  endtask

  // result sink with random stalls
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      stall_left = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) check_temperature(m_axis_tdata);
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else if (sink_idle_en && $urandom_range(0, 99) < 3) begin
        stall_left = pick_gap() - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // watchdog on cycles without any accepted beat
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout after %0d idle cycles, %0d temperatures outstanding",
               idle_cycles, temp_expect_q.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  // reset window, invalid and zero samples, seeding
  task automatic test_reset_window();
    send_sample(1'b0, 1'b0, 10'd1023);
    send_sample(1'b0, 1'b1, 10'd0);
    send_sample(1'b1, 1'b0, 10'd1023);
    send_sample(1'b1, 1'b1, 10'd0);
    end_burst();
  endtask

  // ring stores, ignored samples, seed that leaves the ring position alone
  task automatic test_ring_store();
    send_sample(1'b0, 1'b1, 10'd1023);
    send_sample(1'b0, 1'b1, 10'd512);
    send_sample(1'b0, 1'b1, 10'h155);
    send_sample(1'b0, 1'b1, 10'h2AA);
    send_sample(1'b0, 1'b1, 10'd1);
    send_sample(1'b0, 1'b0, 10'd1000);
    send_sample(1'b0, 1'b1, 10'd0);
    send_sample(1'b1, 1'b1, 10'd600);
    send_sample(1'b0, 1'b1, 10'd1023);
    end_burst();
  endtask

  // highest and lowest temperatures through the offset extremes
  task automatic test_offset_extremes();
    wait_drained();
    set_temp_offset(10'sd511);
    send_sample(1'b1, 1'b0, 10'd1023);
    send_sample(1'b1, 1'b1, 10'd0);
    end_burst();
    wait_drained();
    set_temp_offset(-10'sd512);
    send_sample(1'b1, 1'b0, 10'd0);
    send_sample(1'b1, 1'b1, 10'd1023);
    end_burst();
  endtask

  // phases of noisy sensor readings around a level, with outliers and seeds
  task automatic test_random_traffic();
    logic signed [OFS_W-1:0] ofs;
    int r;
    int v;
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      wait_drained();
      case (phase)
        0:       ofs = '0;
        1:       ofs = 10'sd511;
        2:       ofs = -10'sd512;
        default: ofs = OFS_W'($urandom);
      endcase
      set_temp_offset(ofs);
      src_idle_en  = (phase != 0) && (phase != 1);
      sink_idle_en = (phase != 0) && (phase != 2);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        r = $urandom_range(0, 99);
        if (r < 4) begin
          if ($urandom_range(0, 3) == 0) level = $urandom_range(0, 1023);
          send_sample(1'b1, 1'($urandom), RAW_W'(level));
        end else if (r < 82) begin
          if ($urandom_range(0, 99) < 12) v = $urandom_range(1, 1023);
          else v = level + $urandom_range(0, 16) - 8;
          if (v < 1) v = 1;
          if (v > 1023) v = 1023;
          send_sample(1'b0, 1'b1, RAW_W'(v));
        end else if (r < 90) begin
          send_sample(1'b0, 1'b1, '0);
        end else begin
          send_sample(1'b0, 1'b0, RAW_W'($urandom));
        end
        if ($urandom_range(0, 199) == 0) level = $urandom_range(0, 1023);
      end
      end_burst();
    end
  endtask

  initial begin
    for (int i = 0; i < WINDOW; i++) window_model[i] = '0;
    ring_pos     = 0;
    offset_model = '0;
    level        = 300;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_window();
    test_ring_store();
    test_offset_extremes();
    test_random_traffic();

    // drain, then watch for stray beats
    wait_drained();
    repeat (LATENCY + 16) @(posedge clk_i);

    $display("sent %0d samples (%0d seeds, %0d stored), checked %0d temperatures",
             samples_sent, seeds_sent, stores_sent, temps_checked);
    $display("over %0d offset settings including both extremes", offsets_set);
    if (fail_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+design
design/tmwf_pkg.sv
design/tmwf_ram.sv
design/trimmed_mean_window_filter_top.sv
design/tmwf_checker.sv
tb/tb_trimmed_mean_window_filter_top.sv
